// ===== design/ctmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctmc_pkg
// Types and codes shared by the trailer map checker modules.
// ----------------------------------------------------------------------------
package ctmc_pkg;

  typedef enum logic [8:0] {
    PH_MAP     = 9'b000000001,
    PH_MAP_EXT = 9'b000000010,
    PH_KEY     = 9'b000000100,
    PH_KEY_EXT = 9'b000001000,
    PH_KEY_PAY = 9'b000010000,
    PH_VAL     = 9'b000100000,
    PH_VAL_EXT = 9'b001000000,
    PH_VAL_PAY = 9'b010000000,
    PH_DONE    = 9'b100000000
  } phase_e;

  // byte roles
  localparam logic [2:0] ROLE_MAP_HEAD = 3'd0;
  localparam logic [2:0] ROLE_KEY_HEAD = 3'd1;
  localparam logic [2:0] ROLE_KEY_PAY  = 3'd2;
  localparam logic [2:0] ROLE_VAL_HEAD = 3'd3;
  localparam logic [2:0] ROLE_VAL_PAY  = 3'd4;
  localparam logic [2:0] ROLE_IGNORED  = 3'd5;

  // value kinds
  localparam logic [1:0] KIND_UINT  = 2'd0;
  localparam logic [1:0] KIND_BYTES = 2'd1;
  localparam logic [1:0] KIND_TEXT  = 2'd2;
  localparam logic [1:0] KIND_BOOL  = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TRUNCATED  = 3'd1;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
  localparam logic [2:0] ST_WRONG_TYPE = 3'd3;
  localparam logic [2:0] ST_TOO_MANY   = 3'd4;
  localparam logic [2:0] ST_BAD_VALUE  = 3'd5;
  localparam logic [2:0] ST_TRAILING   = 3'd6;

  // major types
  localparam logic [2:0] MT_UINT  = 3'd0;
  localparam logic [2:0] MT_BYTES = 3'd2;
  localparam logic [2:0] MT_TEXT  = 3'd3;
  localparam logic [2:0] MT_MAP   = 3'd5;
  localparam logic [2:0] MT_SIMPLE = 3'd7;

  // additional info
  localparam logic [4:0] AI_ONE_BYTE = 5'd24;
  localparam logic [4:0] AI_TWO_BYTE = 5'd25;

  localparam logic [15:0] SIMPLE_FALSE = 16'd20;
  localparam logic [15:0] SIMPLE_TRUE  = 16'd21;

  localparam logic [7:0] MAX_ENTRIES_RESET = 8'd32;

  typedef struct packed {
    phase_e      phase;
    logic [1:0]  len_left;
    logic [15:0] accum;
    logic [15:0] pay_left;
    logic [7:0]  entries_left;
    logic [7:0]  cur_entry;
    logic [1:0]  cur_kind;
    logic [2:0]  err;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:        PH_MAP,
    len_left:     2'd0,
    accum:        16'd0,
    pay_left:     16'd0,
    entries_left: 8'd0,
    cur_entry:    8'd0,
    cur_kind:     2'd0,
    err:          3'd0
  };

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  entry;
    logic [1:0]  kind;
    logic [15:0] arg;
    logic        head_done;
    logic        entry_done;
    logic        last;
    logic [2:0]  status;
  } result_t;

endpackage
`default_nettype wire

// ===== design/cbor_trailer_map_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an accepted byte passes the input register, then the result register
// throughput: one byte per cycle while the result side is not stalled; the parse step is combinational
// an input register and a result register decouple both stream sides
// rst_ni clears the parse state, empties both registers and sets max_entries to 32
// the parse state also returns to reset after every last byte
// ----------------------------------------------------------------------------
// cbor_trailer_map_checker
// Checks a trailer body byte stream for one definite-length map of text keys
// and uint, byte string, text or simple values, classifying every byte and reporting a status at the end.
// ----------------------------------------------------------------------------
module cbor_trailer_map_checker
  import ctmc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: max_entries
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // last_byte
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] byte_role, [10:3] entry_index, [12:11] value_kind,
  // [28:13] head_argument, [29] head_complete, [30] entry_complete,
  // [33:31] status, [39:34] zero
  output logic [39:0]      m_tdata,
  output logic             m_tlast    // trailer_done
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_last_q;
  logic         out_valid_q;
  result_t      out_q;
  logic [7:0]   max_entries_q;
  parse_state_t st_q, st_d;
  result_t      res;
  logic         advance;

  assign cfg_ready_o = 1'b1;
  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;

  ctmc_step u_step (
    .st_i          (st_q),
    .byte_i        (in_byte_q),
    .last_i        (in_last_q),
    .max_entries_i (max_entries_q),
    .st_o          (st_d),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENTRIES_RESET;
    end else if (cfg_valid_i) begin
      max_entries_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= PARSE_RESET;
    end else begin
      if (s_tready) in_valid_q <= s_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_byte_q <= s_tdata;
      in_last_q <= s_tlast;
    end
    if (advance) out_q <= res;
  end

  assign m_tvalid = out_valid_q;
  assign m_tlast  = out_q.last;
  assign m_tdata  = {6'd0, out_q.status, out_q.entry_done, out_q.head_done,
                     out_q.arg, out_q.kind, out_q.entry, out_q.role};

`ifndef NO_ASSERTIONS
  // a status other than ok only comes with the final byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && !m_tlast) |-> (out_q.status == ST_OK))
    else $error("status reported on a non-final byte");

  // a completed head never comes from an ignored byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && out_q.head_done) |-> (out_q.role != ROLE_IGNORED))
    else $error("head completed on an ignored byte");

  // an entry ends only on a value byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && out_q.entry_done) |->
      (out_q.role == ROLE_VAL_HEAD || out_q.role == ROLE_VAL_PAY))
    else $error("entry completed on a non-value byte");

  // parse state only moves when a result is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(advance) |-> $stable(st_q))
    else $error("parse state changed without a result");
`endif

endmodule
`default_nettype wire

// ===== design/ctmc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctmc_step
// One byte of parse: classifies the byte and computes the next parse state.
// ----------------------------------------------------------------------------
module ctmc_step
  import ctmc_pkg::*;
(
  input  parse_state_t st_i,
  input  logic [7:0]   byte_i,
  input  logic         last_i,
  input  logic [7:0]   max_entries_i,
  output parse_state_t st_o,
  output result_t      res_o
);

  logic [2:0]   mtype;
  logic [4:0]   info;
  logic         type_ok;
  logic [1:0]   head_kind;
  logic         fin;
  logic [1:0]   fin_cls;   // 0 map, 1 key, 2 value
  logic [15:0]  fin_arg;
  logic         end_entry;
  logic [15:0]  accum_n;
  logic [1:0]   len_n;
  logic [15:0]  pay_n;
  logic [7:0]   entries_n;
  parse_state_t nst;
  result_t      res;

  assign mtype = byte_i[7:5];
  assign info  = byte_i[4:0];
  assign accum_n = {st_i.accum[7:0], byte_i};
  assign len_n   = st_i.len_left - 2'd1;
  assign pay_n   = st_i.pay_left - 16'd1;

  always_comb begin
    case (mtype)
      MT_UINT:  head_kind = KIND_UINT;
      MT_BYTES: head_kind = KIND_BYTES;
      MT_TEXT:  head_kind = KIND_TEXT;
      default:  head_kind = KIND_BOOL;
    endcase
  end

  always_comb begin
    nst = st_i;
    res = '0;
    res.entry = st_i.cur_entry;
    fin = 1'b0;
    fin_cls = 2'd0;
    fin_arg = {11'd0, info};
    end_entry = 1'b0;
    type_ok = 1'b0;
    entries_n = st_i.entries_left - 8'd1;

    if (st_i.err != ST_OK) begin
      res.role = ROLE_IGNORED;
    end else begin
      unique case (st_i.phase)
        PH_MAP, PH_KEY, PH_VAL: begin
          if (st_i.phase == PH_MAP) begin
            res.role = ROLE_MAP_HEAD;
            fin_cls = 2'd0;
            type_ok = (mtype == MT_MAP);
          end else if (st_i.phase == PH_KEY) begin
            res.role = ROLE_KEY_HEAD;
            fin_cls = 2'd1;
            type_ok = (mtype == MT_TEXT);
          end else begin
            res.role = ROLE_VAL_HEAD;
            fin_cls = 2'd2;
            type_ok = (mtype == MT_UINT) || (mtype == MT_BYTES) ||
                      (mtype == MT_TEXT) || (mtype == MT_SIMPLE);
          end
          // length form check comes before the type check
          if (info > AI_TWO_BYTE) begin
            nst.err = ST_BAD_LENGTH;
          end else if (!type_ok) begin
            nst.err = ST_WRONG_TYPE;
          end else begin
            if (st_i.phase == PH_VAL) begin
              nst.cur_kind = head_kind;
              res.kind = head_kind;
            end
            if (info < AI_ONE_BYTE) begin
              fin = 1'b1;
            end else begin
              nst.len_left = (info == AI_ONE_BYTE) ? 2'd1 : 2'd2;
              nst.accum = 16'd0;
              if (st_i.phase == PH_MAP) nst.phase = PH_MAP_EXT;
              else if (st_i.phase == PH_KEY) nst.phase = PH_KEY_EXT;
              else nst.phase = PH_VAL_EXT;
            end
          end
        end
        PH_MAP_EXT, PH_KEY_EXT, PH_VAL_EXT: begin
          if (st_i.phase == PH_MAP_EXT) begin
            res.role = ROLE_MAP_HEAD;
            fin_cls = 2'd0;
          end else if (st_i.phase == PH_KEY_EXT) begin
            res.role = ROLE_KEY_HEAD;
            fin_cls = 2'd1;
          end else begin
            res.role = ROLE_VAL_HEAD;
            fin_cls = 2'd2;
            res.kind = st_i.cur_kind;
          end
          nst.accum = accum_n;
          nst.len_left = len_n;
          fin_arg = accum_n;
          fin = (len_n == 2'd0);
        end
        PH_KEY_PAY: begin
          res.role = ROLE_KEY_PAY;
          nst.pay_left = pay_n;
          if (pay_n == 16'd0) nst.phase = PH_VAL;
        end
        PH_VAL_PAY: begin
          res.role = ROLE_VAL_PAY;
          res.kind = st_i.cur_kind;
          nst.pay_left = pay_n;
          end_entry = (pay_n == 16'd0);
        end
        PH_DONE: begin
          res.role = ROLE_IGNORED;
          nst.err = ST_TRAILING;
        end
        default: begin
          res.role = ROLE_IGNORED;
        end
      endcase

      if (fin) begin
        case (fin_cls)
          2'd0: begin
            if (fin_arg > {8'd0, max_entries_i}) begin
              nst.err = ST_TOO_MANY;
            end else begin
              nst.entries_left = fin_arg[7:0];
              nst.cur_entry = 8'd0;
              nst.phase = (fin_arg == 16'd0) ? PH_DONE : PH_KEY;
              res.arg = fin_arg;
              res.head_done = 1'b1;
            end
          end
          2'd1: begin
            nst.pay_left = fin_arg;
            nst.phase = (fin_arg == 16'd0) ? PH_VAL : PH_KEY_PAY;
            res.arg = fin_arg;
            res.head_done = 1'b1;
          end
          default: begin
            if (nst.cur_kind == KIND_BOOL && fin_arg != SIMPLE_FALSE &&
                fin_arg != SIMPLE_TRUE) begin
              nst.err = ST_BAD_VALUE;
              res.kind = KIND_UINT;
            end else begin
              if (nst.cur_kind == KIND_BYTES || nst.cur_kind == KIND_TEXT) begin
                nst.pay_left = fin_arg;
                if (fin_arg != 16'd0) nst.phase = PH_VAL_PAY;
                else end_entry = 1'b1;
              end else begin
                end_entry = 1'b1;
              end
              res.arg = fin_arg;
              res.head_done = 1'b1;
            end
          end
        endcase
      end

      if (end_entry) begin
        res.entry_done = 1'b1;
        nst.entries_left = entries_n;
        nst.cur_entry = st_i.cur_entry + 8'd1;
        nst.phase = (entries_n == 8'd0) ? PH_DONE : PH_KEY;
      end
    end

    if (last_i) begin
      res.last = 1'b1;
      if (nst.err != ST_OK) res.status = nst.err;
      else res.status = (nst.phase == PH_DONE) ? ST_OK : ST_TRUNCATED;
      nst = PARSE_RESET;
    end
  end

  assign st_o  = nst;
  assign res_o = res;

endmodule
`default_nettype wire

// ===== bench/trailer_parse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trailer_parse_checker
// Follows the limit writes and the byte requests of the trailer map checker,
// works out the classification each byte must get and compares it with the
// result stream, oldest first.
// ----------------------------------------------------------------------------
module trailer_parse_checker
  import ctmc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic        m_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [1:0] {HEAD_MAP, HEAD_KEY, HEAD_VAL} head_class_e;

  localparam logic [4:0]  AI_FIRST_BAD = 5'd26;
  localparam int unsigned REPORT_LIMIT = 10;

  logic [7:0]  limit_q;
  phase_e      phase_q;
  logic [1:0]  ext_left_q;
  logic [15:0] accum_q;
  logic [15:0] pay_left_q;
  logic [15:0] entries_left_q;
  logic [7:0]  entry_q;
  logic [1:0]  kind_q;
  logic [2:0]  err_q;
  result_t     expected_results[$];

  function automatic void clear_parse();
    phase_q        = PH_MAP;
    ext_left_q     = '0;
    accum_q        = '0;
    pay_left_q     = '0;
    entries_left_q = '0;
    entry_q        = '0;
    kind_q         = KIND_UINT;
    err_q          = ST_OK;
  endfunction

  function automatic void close_entry(inout result_t r);
    r.entry_done   = 1'b1;
    entries_left_q = entries_left_q - 16'd1;
    entry_q        = entry_q + 8'd1;
    if (entries_left_q == 16'd0) begin
      phase_q = PH_DONE;
    end else begin
      phase_q = PH_KEY;
    end
  endfunction

  function automatic void finish_head(input head_class_e cls, input logic [15:0] arg,
                                      inout result_t r);
    logic accepted;
    accepted = 1'b1;
    case (cls)
      HEAD_MAP: begin
        if (arg > {8'd0, limit_q}) begin
          err_q    = ST_TOO_MANY;
          accepted = 1'b0;
        end else begin
          entries_left_q = arg;
          entry_q        = '0;
          if (arg == 16'd0) begin
            phase_q = PH_DONE;
          end else begin
            phase_q = PH_KEY;
          end
        end
      end
      HEAD_KEY: begin
        pay_left_q = arg;
        if (arg == 16'd0) begin
          phase_q = PH_VAL;
        end else begin
          phase_q = PH_KEY_PAY;
        end
      end
      default: begin
        if (kind_q == KIND_BOOL && arg != SIMPLE_FALSE && arg != SIMPLE_TRUE) begin
          err_q    = ST_BAD_VALUE;
          r.kind   = KIND_UINT;
          accepted = 1'b0;
        end else if (kind_q == KIND_BYTES || kind_q == KIND_TEXT) begin
          pay_left_q = arg;
          if (arg != 16'd0) begin
            phase_q = PH_VAL_PAY;
          end else begin
            close_entry(r);
          end
        end else begin
          close_entry(r);
        end
      end
    endcase
    if (accepted) begin
      r.arg       = arg;
      r.head_done = 1'b1;
    end
  endfunction

  function automatic void start_head(input head_class_e cls, input logic [7:0] b,
                                     inout result_t r);
    logic [2:0] mt;
    logic [4:0] ai;
    logic       ok;
    mt = b[7:5];
    ai = b[4:0];
    // length form is judged before the major type
    if (ai >= AI_FIRST_BAD) begin
      err_q = ST_BAD_LENGTH;
    end else begin
      case (cls)
        HEAD_MAP: ok = (mt == MT_MAP);
        HEAD_KEY: ok = (mt == MT_TEXT);
        default: begin
          ok = 1'b1;
          case (mt)
            MT_UINT:   kind_q = KIND_UINT;
            MT_BYTES:  kind_q = KIND_BYTES;
            MT_TEXT:   kind_q = KIND_TEXT;
            MT_SIMPLE: kind_q = KIND_BOOL;
            default:   ok = 1'b0;
          endcase
          if (ok) begin
            r.kind = kind_q;
          end
        end
      endcase
      if (!ok) begin
        err_q = ST_WRONG_TYPE;
      end else if (ai < AI_ONE_BYTE) begin
        finish_head(cls, {11'd0, ai}, r);
      end else begin
        ext_left_q = (ai == AI_ONE_BYTE) ? 2'd1 : 2'd2;
        accum_q    = '0;
        case (cls)
          HEAD_MAP: phase_q = PH_MAP_EXT;
          HEAD_KEY: phase_q = PH_KEY_EXT;
          default:  phase_q = PH_VAL_EXT;
        endcase
      end
    end
  endfunction

  function automatic result_t predict_byte_result(input logic [7:0] b, input logic last);
    result_t     r;
    head_class_e cls;
    r       = '0;
    r.entry = entry_q;
    if (err_q != ST_OK) begin
      r.role = ROLE_IGNORED;
    end else begin
      case (phase_q)
        PH_MAP: begin
          r.role = ROLE_MAP_HEAD;
          start_head(HEAD_MAP, b, r);
        end
        PH_KEY: begin
          r.role = ROLE_KEY_HEAD;
          start_head(HEAD_KEY, b, r);
        end
        PH_VAL: begin
          r.role = ROLE_VAL_HEAD;
          start_head(HEAD_VAL, b, r);
        end
        PH_MAP_EXT, PH_KEY_EXT, PH_VAL_EXT: begin
          // extension bytes keep the role of their head
          if (phase_q == PH_MAP_EXT) begin
            cls    = HEAD_MAP;
            r.role = ROLE_MAP_HEAD;
          end else if (phase_q == PH_KEY_EXT) begin
            cls    = HEAD_KEY;
            r.role = ROLE_KEY_HEAD;
          end else begin
            cls    = HEAD_VAL;
            r.role = ROLE_VAL_HEAD;
            r.kind = kind_q;
          end
          accum_q    = {accum_q[7:0], b};
          ext_left_q = ext_left_q - 2'd1;
          if (ext_left_q == 2'd0) begin
            finish_head(cls, accum_q, r);
          end
        end
        PH_KEY_PAY: begin
          r.role     = ROLE_KEY_PAY;
          pay_left_q = pay_left_q - 16'd1;
          if (pay_left_q == 16'd0) begin
            phase_q = PH_VAL;
          end
        end
        PH_VAL_PAY: begin
          r.role     = ROLE_VAL_PAY;
          r.kind     = kind_q;
          pay_left_q = pay_left_q - 16'd1;
          if (pay_left_q == 16'd0) begin
            close_entry(r);
          end
        end
        default: begin
          // anything after a complete map
          r.role = ROLE_IGNORED;
          err_q  = ST_TRAILING;
        end
      endcase
    end
    if (last) begin
      r.last = 1'b1;
      if (err_q != ST_OK) begin
        r.status = err_q;
      end else if (phase_q == PH_DONE) begin
        r.status = ST_OK;
      end else begin
        r.status = ST_TRUNCATED;
      end
      clear_parse();
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t seen;
    result_t want;
    if (!rst_ni) begin
      limit_q = MAX_ENTRIES_RESET;
      clear_parse();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        limit_q = cfg_data_i;
      end
      if (m_tvalid_i && m_tready_i) begin
        seen.role       = m_tdata_i[2:0];
        seen.entry      = m_tdata_i[10:3];
        seen.kind       = m_tdata_i[12:11];
        seen.arg        = m_tdata_i[28:13];
        seen.head_done  = m_tdata_i[29];
        seen.entry_done = m_tdata_i[30];
        seen.status     = m_tdata_i[33:31];
        seen.last       = m_tlast_i;
        if (expected_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= REPORT_LIMIT) begin
            $display("unexpected result tdata=%h tlast=%b with no request pending",
                     m_tdata_i, m_tlast_i);
          end
        end else begin
          want = expected_results.pop_front();
          if (seen.role !== want.role || seen.entry !== want.entry ||
              seen.kind !== want.kind || seen.arg !== want.arg ||
              seen.head_done !== want.head_done || seen.entry_done !== want.entry_done ||
              seen.last !== want.last || seen.status !== want.status ||
              m_tdata_i[39:34] !== 6'd0) begin
            fail_count_o++;
            if (fail_count_o <= REPORT_LIMIT) begin
              $display("result mismatch: exp role %0d entry %0d kind %0d arg %0d hd %b ed %b",
                       want.role, want.entry, want.kind, want.arg, want.head_done,
                       want.entry_done, " last %b status %0d", want.last, want.status);
              $display("                 got role %0d entry %0d kind %0d arg %0d hd %b ed %b",
                       seen.role, seen.entry, seen.kind, seen.arg, seen.head_done,
                       seen.entry_done, " last %b status %0d pad %h", seen.last,
                       seen.status, m_tdata_i[39:34]);
            end
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_results.insert(expected_results.size(),
                                predict_byte_result(s_tdata_i, s_tlast_i));
      end
    end
    pending_o = expected_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams trailer bodies into the map checker: hand-made trailers that cover
// each status, then random maps under several entry limits, mostly well
// formed and partly cut short, padded or corrupted, with random gaps on both
// stream sides. The checker module beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import ctmc_pkg::*;

  localparam int unsigned PHASE_BYTES  = 200;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned IDLE_PERCENT = 14;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  logic        calm;  // no gaps on either side while set
  logic [7:0]  entry_limit;
  logic [7:0]  trailer_bytes[$];
  logic [7:0]  phase_limits[5];
  int unsigned cycle_count = 0;
  int unsigned bytes_sent;
  int unsigned fail_count;
  int unsigned pending;

  // {last, data}: empty map; two-byte count, one-byte key length, largest uint;
  // empty key with false in one-byte form; bad length form that is also the
  // wrong type; wrong type with an extension form; count over the limit;
  // bad simple value followed by an ignored byte; trailing byte; truncated map
  logic [8:0] directed_bytes[$] = '{
    9'h1A0,
    9'h0B9, 9'h000, 9'h001, 9'h078, 9'h001, 9'h07A, 9'h019, 9'h0FF, 9'h1FF,
    9'h0A1, 9'h060, 9'h0F8, 9'h114,
    9'h11B,
    9'h078, 9'h100,
    9'h0B8, 9'h121,
    9'h0A1, 9'h060, 9'h0F6, 9'h100,
    9'h0A0, 9'h100,
    9'h0A1, 9'h160
  };

  cbor_trailer_map_checker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  trailer_parse_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tlast_i   (m_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    do @(posedge clk_i); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_trailer();
    foreach (trailer_bytes[k]) begin
      send_byte(trailer_bytes[k], k == trailer_bytes.size() - 1);
    end
  endtask

  // hold the byte side until every result is back, then let the pipe settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_entry_limit(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    entry_limit = v;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    trailer_bytes.insert(trailer_bytes.size(), b);
  endfunction

  // head in a random legal length form that can carry arg
  task automatic put_head(input logic [2:0] mt, input int unsigned arg);
    int unsigned form;
    if (arg < 24) begin
      form = $urandom_range(0, 5);
    end else if (arg < 256) begin
      form = $urandom_range(4, 5);
    end else begin
      form = 5;
    end
    if (form < 4) begin
      add_byte({mt, arg[4:0]});
    end else if (form == 4) begin
      add_byte({mt, AI_ONE_BYTE});
      add_byte(arg[7:0]);
    end else begin
      add_byte({mt, AI_TWO_BYTE});
      add_byte(arg[15:8]);
      add_byte(arg[7:0]);
    end
  endtask

  function automatic int unsigned pick_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(24, 40) : $urandom_range(0, 5);
  endfunction

  task automatic put_string(input logic [2:0] mt, input int unsigned len);
    put_head(mt, len);
    repeat (len) add_byte(8'($urandom));
  endtask

  task automatic build_trailer();
    int unsigned n;
    int unsigned pick;
    int unsigned num;
    trailer_bytes.delete();
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      n = entry_limit + 1;
    end else if (pick == 1 && entry_limit <= 40) begin
      n = entry_limit;
    end else begin
      n = $urandom_range(0, (entry_limit < 6) ? entry_limit : 6);
    end
    put_head(MT_MAP, n);
    // an over-limit map is rejected at its head, a single entry is enough
    repeat ((n > entry_limit) ? 1 : n) begin
      put_string(MT_TEXT, pick_length());
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 3))
            0:       num = $urandom_range(0, 23);
            1:       num = $urandom_range(24, 255);
            2:       num = $urandom_range(256, 65535);
            default: num = ($urandom_range(0, 1) == 1) ? 65535 : 0;
          endcase
          put_head(MT_UINT, num);
        end
        1: put_string(MT_BYTES, pick_length());
        2: put_string(MT_TEXT, pick_length());
        default: begin
          if ($urandom_range(0, 11) == 0) begin
            put_head(MT_SIMPLE, $urandom_range(0, 255));
          end else begin
            put_head(MT_SIMPLE, $urandom_range(SIMPLE_FALSE, SIMPLE_TRUE));
          end
        end
      endcase
    end
    // damage some of the trailers
    pick = $urandom_range(0, 99);
    if (pick < 8 && trailer_bytes.size() > 1) begin
      repeat ($urandom_range(1, trailer_bytes.size() - 1)) void'(trailer_bytes.pop_back());
    end else if (pick < 15) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
    end else if (pick < 25) begin
      trailer_bytes[$urandom_range(0, trailer_bytes.size() - 1)] = 8'($urandom);
    end else if (pick < 29) begin
      trailer_bytes.delete();
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom));
    end
  endtask

  initial begin
    int unsigned target;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    calm        = 1'b0;
    entry_limit = MAX_ENTRIES_RESET;
    bytes_sent  = 0;
    phase_limits = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(2, 254)), 8'd5};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[k]) begin
      send_byte(directed_bytes[k][7:0], directed_bytes[k][8]);
    end

    foreach (phase_limits[p]) begin
      wait_drained();
      write_entry_limit(phase_limits[p]);
      calm = (p == 2);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_trailer();
        send_trailer();
      end
    end
    calm = 1'b0;
    wait_drained();

    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== cbor_trailer_map_checker.f =====
design/ctmc_pkg.sv
design/ctmc_step.sv
design/cbor_trailer_map_checker.sv
bench/trailer_parse_checker.sv
bench/tb_top.sv
